FILE: rtl/ffa_pkg.sv
package ffa_pkg;

    localparam int unsigned GRANULE_SHIFT = 4;
    localparam int unsigned REQ_BYTES_W   = 32;
    localparam int unsigned NEED_W        = REQ_BYTES_W - GRANULE_SHIFT + 1;
    localparam int unsigned OFFSET_W      = 16;
    localparam int unsigned REMAIN_W      = 17;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_AWALK  = 11'b000_0000_0010,
        S_AREAD  = 11'b000_0000_0100,
        S_ASPLIT = 11'b000_0000_1000,
        S_FWALK  = 11'b000_0001_0000,
        S_FREAD  = 11'b000_0010_0000,
        S_FHEAD  = 11'b000_0100_0000,
        S_FNEXT  = 11'b000_1000_0000,
        S_FPCHK  = 11'b001_0000_0000,
        S_FPREV  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

endpackage

FILE: rtl/first_fit_arena_allocator_core.sv
// First-fit arena allocator with coalescing. Each accepted item is either an
// allocate or a free, and each produces exactly one result item. Block headers
// live in one single-port-write RAM of ARENA_UNITS entries. An allocate walks
// the block chain, reading the header of each block visited, then writes one
// or two headers, or none when it fails. A free walks the chain to the released
// block and then reads its neighbors and merges the free ones with it.
// Zero-byte allocations leave blocks of a bare header, so up to
// ARENA_UNITS/HEADER_UNITS blocks can exist. Only one item is in work at a
// time; a finished result waits in the output register.
module first_fit_arena_allocator_core #(
    parameter int unsigned ARENA_UNITS  = 4096,
    parameter int unsigned HEADER_UNITS = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_request_bytes,
    input  logic [15:0] s_release_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_granted_offset,
    output logic        m_success,
    output logic [16:0] m_remaining_bytes
);
    import ffa_pkg::*;

    localparam int unsigned AW = $clog2(ARENA_UNITS);
    localparam int unsigned CW = AW + 2;
    localparam logic [CW-1:0] HDR_C = CW'(HEADER_UNITS);
    localparam logic [AW:0] ARENA_C = (AW + 1)'(ARENA_UNITS);

    state_t state_reg, state_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic has_prev_reg, has_prev_next;
    logic [CW-1:0] h_reg, h_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [AW-1:0] size_h_reg, size_h_next;
    logic [AW:0] hw_reg, hw_next;
    logic [AW:0] free_reg, free_next;
    logic ok_reg, ok_next;
    logic [CW-1:0] grant_reg, grant_next;
    logic m_valid_reg, m_valid_next;
    logic [15:0] m_granted_reg, m_granted_next;
    logic m_success_reg, m_success_next;
    logic [16:0] m_remain_reg, m_remain_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [AW:0] wdata, rdata;
    logic [AW-1:0] rd_size;
    logic rd_used;
    logic [CW-1:0] nxt;
    logic [AW-1:0] leftover;
    logic [NEED_W:0] needed;
    logic [AW:0] room;
    logic [AW+1:0] remain_units;
    logic [CW-1:0] cur_hdr;

    ffa_ram #(.WIDTH(AW + 1), .DEPTH(ARENA_UNITS)) u_hdr_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_size = rdata[AW-1:0];
    assign rd_used = rdata[AW];
    assign nxt = cur_reg + HDR_C + CW'(rd_size);
    assign leftover = rd_size - need_reg[AW-1:0];
    assign needed = (NEED_W + 1)'(HEADER_UNITS) + (NEED_W + 1)'(need_reg);
    assign room = ARENA_C - hw_reg;
    assign cur_hdr = cur_reg + HDR_C;
    assign remain_units = (AW + 2)'(ARENA_C) - (AW + 2)'(hw_reg) + (AW + 2)'(free_reg);

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        has_prev_next = has_prev_reg;
        h_next = h_reg;
        need_next = need_reg;
        size_h_next = size_h_reg;
        hw_next = hw_reg;
        free_next = free_reg;
        ok_next = ok_reg;
        grant_next = grant_reg;
        m_valid_next = m_valid_reg;
        m_granted_next = m_granted_reg;
        m_success_next = m_success_reg;
        m_remain_next = m_remain_reg;
        we = 1'b0;
        waddr = cur_reg[AW-1:0];
        wdata = '0;
        raddr = cur_reg[AW-1:0];
        s_ready = (state_reg == S_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cur_next = '0;
                    prev_next = '0;
                    has_prev_next = 1'b0;
                    grant_next = '0;
                    ok_next = 1'b0;
                    need_next = NEED_W'(({1'b0, s_request_bytes} + 33'd15) >> GRANULE_SHIFT);
                    h_next = CW'(s_release_offset[15:GRANULE_SHIFT]) - HDR_C;
                    if (s_op == OP_ALLOCATE) begin
                        state_next = S_AWALK;
                    end else if (s_release_offset == '0) begin
                        ok_next = 1'b1;
                        state_next = S_DONE;
                    end else if (s_release_offset[GRANULE_SHIFT-1:0] != '0 ||
                                 CW'(s_release_offset[15:GRANULE_SHIFT]) < HDR_C) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FWALK;
                    end
                end
            end
            S_AWALK: begin
                if (CW'(hw_reg) > cur_reg) begin
                    state_next = S_AREAD;
                end else begin
                    if (needed <= (NEED_W + 1)'(room)) begin
                        we = 1'b1;
                        waddr = hw_reg[AW-1:0];
                        wdata = {1'b1, need_reg[AW-1:0]};
                        hw_next = hw_reg + (AW + 1)'(needed);
                        grant_next = CW'(hw_reg) + HDR_C;
                        ok_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_AREAD: begin
                if (!rd_used && NEED_W'(rd_size) >= need_reg) begin
                    grant_next = cur_hdr;
                    ok_next = 1'b1;
                    if (leftover >= AW'(HEADER_UNITS + 1)) begin
                        we = 1'b1;
                        waddr = AW'(cur_hdr + CW'(need_reg[AW-1:0]));
                        wdata = {1'b0, leftover - AW'(HEADER_UNITS)};
                        free_next = free_reg - (AW + 1)'(need_reg[AW-1:0]) -
                                    (AW + 1)'(HEADER_UNITS);
                        state_next = S_ASPLIT;
                    end else begin
                        we = 1'b1;
                        wdata = {1'b1, rd_size};
                        free_next = free_reg - (AW + 1)'(rd_size);
                        state_next = S_DONE;
                    end
                end else begin
                    cur_next = nxt;
                    state_next = S_AWALK;
                end
            end
            S_ASPLIT: begin
                we = 1'b1;
                wdata = {1'b1, need_reg[AW-1:0]};
                state_next = S_DONE;
            end
            S_FWALK: begin
                if (CW'(hw_reg) > cur_reg && cur_reg != h_reg) begin
                    prev_next = cur_reg;
                    has_prev_next = 1'b1;
                    state_next = S_FREAD;
                end else if (cur_reg != h_reg || cur_reg >= CW'(hw_reg)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FHEAD;
                end
            end
            S_FREAD: begin
                cur_next = nxt;
                state_next = S_FWALK;
            end
            S_FHEAD: begin
                if (!rd_used) begin
                    state_next = S_DONE;
                end else begin
                    ok_next = 1'b1;
                    size_h_next = rd_size;
                    free_next = free_reg + (AW + 1)'(rd_size);
                    cur_next = nxt;
                    if (nxt < CW'(hw_reg)) begin
                        raddr = nxt[AW-1:0];
                        state_next = S_FNEXT;
                    end else begin
                        we = 1'b1;
                        waddr = h_reg[AW-1:0];
                        wdata = {1'b0, rd_size};
                        state_next = S_FPCHK;
                    end
                end
            end
            S_FNEXT: begin
                we = 1'b1;
                waddr = h_reg[AW-1:0];
                if (!rd_used) begin
                    size_h_next = size_h_reg + AW'(HEADER_UNITS) + rd_size;
                    wdata = {1'b0, size_h_reg + AW'(HEADER_UNITS) + rd_size};
                    free_next = free_reg + (AW + 1)'(HEADER_UNITS);
                end else begin
                    wdata = {1'b0, size_h_reg};
                end
                state_next = S_FPCHK;
            end
            S_FPCHK: begin
                raddr = prev_reg[AW-1:0];
                state_next = has_prev_reg ? S_FPREV : S_DONE;
            end
            S_FPREV: begin
                if (!rd_used) begin
                    we = 1'b1;
                    waddr = prev_reg[AW-1:0];
                    wdata = {1'b0, rd_size + AW'(HEADER_UNITS) + size_h_reg};
                    free_next = free_reg + (AW + 1)'(HEADER_UNITS);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_granted_next = ok_reg ? 16'({grant_reg, 4'b0}) : '0;
                    m_success_next = ok_reg;
                    m_remain_next = 17'({remain_units, 4'b0});
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hw_reg <= '0;
            free_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hw_reg <= hw_next;
            free_reg <= free_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        has_prev_reg <= has_prev_next;
        h_reg <= h_next;
        need_reg <= need_next;
        size_h_reg <= size_h_next;
        ok_reg <= ok_next;
        grant_reg <= grant_next;
        m_granted_reg <= m_granted_next;
        m_success_reg <= m_success_next;
        m_remain_reg <= m_remain_next;
    end

    assign m_valid = m_valid_reg;
    assign m_granted_offset = m_granted_reg;
    assign m_success = m_success_reg;
    assign m_remaining_bytes = m_remain_reg;

    a_hw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg <= ARENA_C)
        else $error("High-water mark beyond the arena.");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= hw_reg)
        else $error("Free payload count exceeds the block chain.");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !we)
        else $error("Header write while no item is in work.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("New item taken while one is in work.");

endmodule

FILE: rtl/ffa_ram.sv
module ffa_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
